// ===== hdl/iea_pkg.sv =====
// Shared types and constants for the insertable element array.
`default_nettype none

package iea_pkg;

   localparam int WORD_W  = 32;
   localparam int INDEX_W = 4;
   localparam int OP_W    = 3;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;
   localparam int START_W = 5;

   localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
   localparam logic [OP_W-1:0] OP_READ      = 3'd1;
   localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE     = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT    = 3'd4;
   localparam logic [OP_W-1:0] OP_RESTART   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              wr_count;
      logic              wr_index;
      logic              shift_down;
      logic              shift_up;
      logic              clear;
      logic [WORD_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      logic [COUNT_W-1:0]       element_count;
      logic [STAT_W-1:0]        status;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/iea_cell.sv =====
// One storage cell of the element chain, moving its word with its neighbors.
`default_nettype none

module iea_cell import iea_pkg::*; #(
   parameter int POS = 0,
   parameter int WW  = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_cmd_type      cmd,
   input  wire logic [WW-1:0]     idx_ext,
   input  wire logic [WW-1:0]     cnt_ext,
   input  wire logic [WORD_W-1:0] left_word,
   input  wire logic [WORD_W-1:0] right_word,
   output logic      [WORD_W-1:0] word
);

   localparam logic [WW-1:0] MY_POS = WW'(POS);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.clear) begin
         word_in = EMPTY_WORD;
      end else if (cmd.wr_count && (cnt_ext == MY_POS)) begin
         word_in = cmd.value;
      end else if (cmd.wr_index && (idx_ext == MY_POS)) begin
         word_in = cmd.value;
      end else if (cmd.shift_down && (MY_POS >= idx_ext)) begin
         word_in = right_word;
      end else if (cmd.shift_up && (MY_POS > idx_ext)) begin
         word_in = left_word;
      end else if (cmd.shift_up && (MY_POS == idx_ext)) begin
         word_in = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= EMPTY_WORD;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule

`default_nettype wire

// ===== hdl/iea_ctrl.sv =====
// Operation decode, element count and start count register for the array.
`default_nettype none

module iea_ctrl import iea_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int CW       = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [OP_W-1:0]    operation,
   input  wire logic [INDEX_W-1:0] index,
   input  wire logic [WORD_W-1:0]  value,
   input  wire logic [WORD_W-1:0]  rd_word,
   input  wire logic               csr_valid,
   input  wire logic [START_W-1:0] csr_data,
   output cell_cmd_type            cmd,
   output logic      [CW-1:0]      count_q,
   output result_type              result
);

   localparam int VW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int SW = (CW > START_W) ? CW : START_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [START_W-1:0] start_ff;
   logic [SW-1:0]      start_ext;
   logic               in_range;
   logic               full;
   cell_cmd_type       cmd_raw;
   logic [WORD_W-1:0]  rd_val;
   logic [STAT_W-1:0]  stat;

   assign in_range  = VW'(index) < VW'(count_ff);
   assign full      = count_ff == CAP_C;
   assign start_ext = SW'(start_ff);

   always_comb begin
      cmd_raw       = '0;
      cmd_raw.value = value;
      count_in      = count_ff;
      rd_val        = '0;
      stat          = ST_OK;
      case (operation)
         OP_APPEND: begin
            if (full) begin
               stat = ST_FULL;
            end else begin
               cmd_raw.wr_count = 1'b1;
               count_in         = count_ff + ONE_C;
            end
         end
         OP_READ: begin
            if (in_range) begin
               rd_val = rd_word;
            end else begin
               rd_val = EMPTY_WORD;
               stat   = ST_RANGE;
            end
         end
         OP_OVERWRITE: begin
            if (in_range) begin
               cmd_raw.wr_index = 1'b1;
            end else begin
               stat = ST_RANGE;
            end
         end
         OP_ERASE: begin
            if (in_range) begin
               cmd_raw.shift_down = 1'b1;
               count_in           = count_ff - ONE_C;
            end else begin
               stat = ST_RANGE;
            end
         end
         OP_INSERT: begin
            if (!in_range) begin
               stat = ST_RANGE;
            end else if (full) begin
               stat = ST_FULL;
            end else begin
               cmd_raw.shift_up = 1'b1;
               count_in         = count_ff + ONE_C;
            end
         end
         OP_RESTART: begin
            cmd_raw.clear = 1'b1;
            count_in      = (start_ext > CAP_S) ? CAP_C : CW'(start_ext);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd            = cmd_raw;
      cmd.wr_count   = cmd_raw.wr_count & accept;
      cmd.wr_index   = cmd_raw.wr_index & accept;
      cmd.shift_down = cmd_raw.shift_down & accept;
      cmd.shift_up   = cmd_raw.shift_up & accept;
      cmd.clear      = cmd_raw.clear & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         start_ff <= '0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_valid) begin
            start_ff <= csr_data;
         end
      end
   end

   assign count_q              = count_ff;
   assign result.read_value    = rd_val;
   assign result.element_count = COUNT_W'(count_in);
   assign result.status        = stat;

endmodule

`default_nettype wire

// ===== hdl/insertable_element_array.sv =====
// Top level of the insertable element array: cell chain, read select and result register.
//
// The block keeps an ordered array of up to CAPACITY signed 32-bit elements.
// Items enter on the req_ channel: req_tuser carries the operation, req_tdata
// the index and value. Each item gives exactly one result item on the rsp_
// channel with the read value, the element count after the operation and a
// status code. Insert and erase move the elements from the index on in the
// same cycle, since each cell loads from its left or right neighbor at once.
// rsp_tvalid rises in the cycle after acceptance; the block takes one
// item per cycle, set by the single result register, as long as results are
// taken. When the receiver stalls, the result waits in its register and
// req_tready drops until it is taken, so a single item can be held back.
// The csr_ channel writes the start count used by restart; it is always
// ready and is meant to be written while no item is in flight.
// Reset clears the count and the start count, fills every element with -1
// and empties the result register, all in the reset cycle.
`default_nettype none

module insertable_element_array import iea_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,  // index[3:0], value[35:4], zero pad
   input  wire logic [2:0]   req_tuser,  // operation[2:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [39:0]  rsp_tdata,  // read_value[31:0], element_count[36:32], zero pad
   output logic      [1:0]   rsp_tuser,  // status[1:0]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [4:0]   csr_data    // start_count[4:0]
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int WW     = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int RD_N   = 1 << INDEX_W;

   logic                accept;
   cell_cmd_type        cmd;
   logic [CW-1:0]       count_q;
   result_type          result;
   logic [WORD_W-1:0]   cell_word [CAPACITY];
   logic [WORD_W-1:0]   rd_tab [RD_N];
   logic [WORD_W-1:0]   rd_word;
   logic [INDEX_W-1:0]  req_index;
   logic [WORD_W-1:0]  req_value;
   logic [WW-1:0]       idx_ext;
   logic [WW-1:0]       cnt_ext;

   logic                rsp_valid_ff;
   result_type          rsp_ff;

   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_value  = req_tdata[INDEX_W+WORD_W-1:INDEX_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign idx_ext    = WW'(req_index);
   assign cnt_ext    = WW'(count_q);

   iea_ctrl #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_tuser),
      .index     (req_index),
      .value     (req_value),
      .rd_word   (rd_word),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .count_q   (count_q),
      .result    (result)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = EMPTY_WORD;
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = EMPTY_WORD;
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end

      iea_cell #(
         .POS (i),
         .WW  (WW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .idx_ext    (idx_ext),
         .cnt_ext    (cnt_ext),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   for (genvar j = 0; j < RD_N; j++) begin : g_rd
      if (j < CAPACITY) begin : g_used
         assign rd_tab[j] = cell_word[j];
      end else begin : g_unused
         assign rd_tab[j] = EMPTY_WORD;
      end
   end

   assign rd_word = rd_tab[req_index];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.element_count, rsp_ff.read_value};
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire

// ===== hdl/iea_checker.sv =====
// Port-level checks for the insertable element array, bound to the top level.
`default_nettype none

module iea_checker import iea_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [39:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   localparam logic [COUNT_W-1:0] CAP_5 = COUNT_W'(CAPACITY);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined status code");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> rsp_tdata[36:32] == CAP_5)
      else $error("full status with count below capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 31) || (rsp_tdata[36:32] <= CAP_5))
      else $error("element count above capacity");

endmodule

bind insertable_element_array iea_checker #(.CAPACITY(CAPACITY)) u_iea_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the insertable element array stream block.
`timescale 1ns / 100ps

module tb;
   import iea_pkg::*;

   localparam int CAP = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_AT_RESULT = 300;
   localparam int HOLD_CYCLES = 250;
   localparam int PHASE_ITEMS = 197;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic [INDEX_W-1:0]        index;
      logic signed [WORD_W-1:0]  value;
   } array_cmd_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_data = '0;

   array_cmd_type pending_items[$];
   result_type    expected_results[$];

   logic [WORD_W-1:0]  model_cells[CAP];
   int                 model_count = 0;
   logic [START_W-1:0] model_start_count = '0;

   bit  req_fire = 0;
   bit  rsp_fire = 0;
   int  results_seen = 0;
   int  items_queued = 0;
   int  csr_writes = 0;
   int  error_count = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   bit  send_slow = 1;
   int  rsp_wait = 0;
   bit  recv_slow = 1;
   int  hold_left = 0;
   bit  hold_done = 0;

   insertable_element_array #(.CAPACITY(CAP)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < CAP; i++) model_cells[i] = EMPTY_WORD;
   end

   function automatic result_type apply_array_op(logic [OP_W-1:0] op,
                                                 logic [INDEX_W-1:0] idx,
                                                 logic [WORD_W-1:0] val);
      result_type r;
      bit         in_range;
      r.read_value = '0;
      r.status = ST_OK;
      in_range = (int'(idx) < model_count);
      case (op)
         OP_APPEND: begin
            if (model_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               model_cells[model_count] = val;
               model_count++;
            end
         end
         OP_READ: begin
            if (in_range) begin
               r.read_value = model_cells[idx];
            end else begin
               r.read_value = EMPTY_WORD;
               r.status = ST_RANGE;
            end
         end
         OP_OVERWRITE: begin
            if (in_range) model_cells[idx] = val;
            else r.status = ST_RANGE;
         end
         OP_ERASE: begin
            if (in_range) begin
               for (int i = idx; i + 1 < model_count; i++) model_cells[i] = model_cells[i+1];
               model_count--;
               model_cells[model_count] = EMPTY_WORD;
            end else begin
               r.status = ST_RANGE;
            end
         end
         OP_INSERT: begin
            if (!in_range) begin
               r.status = ST_RANGE;
            end else if (model_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               for (int i = model_count; i > idx; i--) model_cells[i] = model_cells[i-1];
               model_cells[idx] = val;
               model_count++;
            end
         end
         OP_RESTART: begin
            for (int i = 0; i < CAP; i++) model_cells[i] = EMPTY_WORD;
            model_count = (int'(model_start_count) > CAP) ? CAP : int'(model_start_count);
         end
         default: ;
      endcase
      r.element_count = COUNT_W'(model_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 50)
         $display("mismatch at result %0d: %s got %h, expected %h", results_seen, what, got, want);
   endtask

   // Acceptance on all channels, checking of results and the watchdog.
   always @(posedge clock) begin
      result_type want;
      req_fire = 0;
      rsp_fire = 0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_fire = 1;
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.read_value)
                  report_mismatch("read_value", rsp_tdata[31:0], want.read_value);
               if (rsp_tdata[36:32] !== want.element_count)
                  report_mismatch("element_count", 32'(rsp_tdata[36:32]),
                                  32'(want.element_count));
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
            end
         end
         if (req_tvalid && req_tready) begin
            req_fire = 1;
            expected_results.insert(expected_results.size(),
                                    apply_array_op(req_tuser, req_tdata[3:0],
                                                   req_tdata[35:4]));
         end
         if (csr_valid && csr_ready) begin
            model_start_count = csr_data;
            csr_writes++;
         end
         if (req_fire || rsp_fire || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Sender: holds each item until taken, then waits a random gap.
   always @(negedge clock) begin
      array_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
         nxt = pending_items.pop_front();
         req_tuser <= nxt.op;
         req_tdata <= {4'b0000, nxt.value, nxt.index};
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 63) == 0) send_slow = !send_slow;
         send_gap = send_slow ? $urandom_range(0, 14) : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: random stall after each item, plus one long hold-off.
   always @(negedge clock) begin
      if (rsp_fire) begin
         if ($urandom_range(0, 63) == 0) recv_slow = !recv_slow;
         rsp_wait = recv_slow ? $urandom_range(0, 14) : 0;
      end
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic queue_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0] val);
      array_cmd_type c;
      c.op = op;
      c.index = idx;
      c.value = val;
      pending_items.insert(pending_items.size(), c);
      items_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (results_seen != items_queued);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_start_count(input logic [START_W-1:0] v);
      int seen;
      wait_drained();
      seen = csr_writes;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(negedge clock); while (csr_writes == seen);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_item(input bit grow);
      int                r;
      int                add_w;
      int                del_w;
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] val;
      r = $urandom_range(0, 99);
      add_w = grow ? 30 : 12;
      del_w = grow ? 8 : 25;
      if (r < 2) op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      else if (r < 5) op = OP_RESTART;
      else if (r < 5 + add_w) op = OP_APPEND;
      else if (r < 5 + 2 * add_w) op = OP_INSERT;
      else if (r < 5 + 2 * add_w + del_w) op = OP_ERASE;
      else if (r < 5 + 2 * add_w + del_w + (95 - 2 * add_w - del_w) / 2) op = OP_READ;
      else op = OP_OVERWRITE;
      case ($urandom_range(0, 19))
         0: val = 32'h7FFF_FFFF;
         1: val = 32'h8000_0000;
         2: val = '0;
         3: val = EMPTY_WORD;
         default: val = $urandom;
      endcase
      queue_item(op, $urandom_range(0, 2) == 0 ? INDEX_W'($urandom_range(0, 15))
                                               : INDEX_W'($urandom_range(0, 7)),
                 val);
   endtask

   initial begin
      logic [START_W-1:0] phase_start[8];
      phase_start = '{5'd16, 5'd0, 5'd5, 5'd17, 5'd1, 5'd15, 5'd0, 5'd31};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty array, then a few elements with extreme values.
      queue_item(OP_READ, 4'd0, '0);
      queue_item(OP_ERASE, 4'd0, '0);
      queue_item(OP_INSERT, 4'd0, 32'h1111_1111);
      queue_item(OP_OVERWRITE, 4'd15, 32'h2222_2222);
      queue_item(OP_APPEND, 4'd15, 32'h7FFF_FFFF);
      queue_item(OP_APPEND, 4'd0, 32'h8000_0000);
      queue_item(OP_APPEND, 4'd0, '0);
      queue_item(OP_READ, 4'd1, '0);
      queue_item(OP_INSERT, 4'd0, 32'h1234_5678);
      queue_item(OP_READ, 4'd0, '0);
      queue_item(OP_ERASE, 4'd3, '0);
      queue_item(OP_READ, 4'd3, '0);
      queue_item(OP_SPARE_6, 4'd2, 32'hDEAD_BEEF);
      queue_item(OP_SPARE_7, 4'd1, 32'hFFFF_FFFF);
      queue_item(OP_OVERWRITE, 4'd0, 32'h5555_5555);
      queue_item(OP_RESTART, 4'd0, '0);

      // Restart with a start count above capacity saturates and fills the array.
      write_start_count(5'd31);
      queue_item(OP_RESTART, 4'd0, '0);
      queue_item(OP_APPEND, 4'd0, 32'h0BAD_F00D);
      queue_item(OP_INSERT, 4'd15, 32'h0BAD_F00D);
      queue_item(OP_READ, 4'd15, '0);
      queue_item(OP_ERASE, 4'd0, '0);
      queue_item(OP_ERASE, 4'd14, '0);
      queue_item(OP_INSERT, 4'd0, 32'hAAAA_AAAA);
      queue_item(OP_OVERWRITE, 4'd13, 32'h8000_0001);
      queue_item(OP_READ, 4'd13, '0);

      for (int p = 0; p < 8; p++) begin
         write_start_count(p == 6 ? START_W'($urandom_range(0, 31)) : phase_start[p]);
         queue_item(OP_RESTART, 4'd0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) queue_random_item(p % 2 == 0);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
